@@ hw/rtl/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the thread scheduler
// Event codes, status codes, link write request and id reduction helper.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int KIND_W   = 3;
    localparam int TID_W    = 4;
    localparam int SID_W    = 3;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int SEM_W    = 8;
    localparam int TID_MAX_W = 8;   // widest slot index (256 slots)

    localparam logic signed [SEM_W-1:0] SEM_MIN = 8'sh80;
    localparam logic signed [SEM_W-1:0] SEM_MAX = 8'sh7f;

    typedef enum logic [KIND_W-1:0] {
        K_CREATE    = 3'd0,
        K_YIELD     = 3'd1,
        K_TERMINATE = 3'd2,
        K_SEM_INIT  = 3'd3,
        K_SEM_WAIT  = 3'd4,
        K_SEM_SIG   = 3'd5,
        K_SEM_DEST  = 3'd6
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EXISTS = 2'd1,
        ST_NO_RUN = 2'd2,
        ST_LIMIT  = 2'd3
    } t_status;

    // one write into the next-pointer store
    typedef struct packed {
        logic                 en;
        logic [TID_MAX_W-1:0] addr;
        logic [TID_MAX_W-1:0] data;
    } t_link_wr;

    // small value modulo a constant count, by repeated subtraction
    function automatic logic [7:0] mod_small(logic [7:0] v, int unsigned n);
        logic [7:0] r;
        r = v;
        for (int i = 0; i < 8; i++) begin
            if (32'(r) >= n) begin
                r = r - 8'(n);
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/sts_if.sv @@
// ----------------------------------------------------------------------------
// sts_if: request and result channels of the thread scheduler
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface sts_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] thread_slot;
    logic [2:0] sem_id;
    logic [6:0] init_count;

    modport source (output valid, output kind, output thread_slot, output sem_id,
                    output init_count, input ready);
    modport sink   (input valid, input kind, input thread_slot, input sem_id,
                    input init_count, output ready);
endinterface

interface sts_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] running_thread;
    logic       running_present;
    logic       switched;
    logic [1:0] status;

    modport source (output valid, output running_thread, output running_present,
                    output switched, output status, input ready);
    modport sink   (input valid, input running_thread, input running_present,
                    input switched, input status, output ready);
endinterface

@@ hw/rtl/sts_link_mem.sv @@
// ----------------------------------------------------------------------------
// sts_link_mem: per-thread next-pointer store
// One write port, two registered read ports with same-cycle write bypass.
// ----------------------------------------------------------------------------
module sts_link_mem #(
    parameter int THREAD_SLOTS = 16
) (
    input  logic                              i_clk,
    input  sts_pkg::t_link_wr                 i_wr,
    input  logic [$clog2(THREAD_SLOTS)-1:0]   i_ready_addr,
    input  logic [$clog2(THREAD_SLOTS)-1:0]   i_wait_addr,
    input  logic                              i_wait_load,
    output logic [$clog2(THREAD_SLOTS)-1:0]   o_ready_next,
    output logic [$clog2(THREAD_SLOTS)-1:0]   o_wait_next
);
    import sts_pkg::*;

    localparam int TW = $clog2(THREAD_SLOTS);

    logic [TW-1:0] r_link [THREAD_SLOTS];
    logic [TW-1:0] r_ready_next;
    logic [TW-1:0] r_wait_next;
    logic [TW-1:0] wr_addr;
    logic [TW-1:0] wr_data;

    assign wr_addr = i_wr.addr[TW-1:0];
    assign wr_data = i_wr.data[TW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_link[wr_addr] <= wr_data;
        end
        // ready head lookahead, refreshed every cycle
        if (i_wr.en && wr_addr == i_ready_addr) begin
            r_ready_next <= wr_data;
        end else begin
            r_ready_next <= r_link[i_ready_addr];
        end
        // wait head lookahead, taken with each new request
        if (i_wait_load) begin
            if (i_wr.en && wr_addr == i_wait_addr) begin
                r_wait_next <= wr_data;
            end else begin
                r_wait_next <= r_link[i_wait_addr];
            end
        end
    end

    assign o_ready_next = r_ready_next;
    assign o_wait_next  = r_wait_next;

endmodule

@@ hw/rtl/sts_sched_core.sv @@
// ----------------------------------------------------------------------------
// sts_sched_core: scheduler state and event logic
// Running thread, ready queue, live flags and semaphores; one event per fire.
// ----------------------------------------------------------------------------
module sts_sched_core #(
    parameter int THREAD_SLOTS = 16,
    parameter int SEMAPHORES   = 8
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_fire,
    input  logic [sts_pkg::KIND_W-1:0]                        i_kind,
    input  logic [$clog2(THREAD_SLOTS)-1:0]                   i_tid,
    input  logic [((SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1)-1:0] i_sem,
    input  logic [sts_pkg::COUNT_W-1:0]                       i_count,
    input  logic [((SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1)-1:0] i_new_sem,
    input  logic [$clog2(THREAD_SLOTS)-1:0]                   i_ready_next,
    input  logic [$clog2(THREAD_SLOTS)-1:0]                   i_wait_next,
    output sts_pkg::t_link_wr                                 o_link_wr,
    output logic [$clog2(THREAD_SLOTS)-1:0]                   o_ready_addr,
    output logic [$clog2(THREAD_SLOTS)-1:0]                   o_wait_addr,
    output logic [sts_pkg::TID_W-1:0]                         o_thread,
    output logic                                              o_present,
    output logic                                              o_switched,
    output logic [sts_pkg::STATUS_W-1:0]                      o_status
);
    import sts_pkg::*;

    localparam int TW = $clog2(THREAD_SLOTS);
    localparam int OW = (TW > TID_W) ? TW : TID_W;

    logic [TW-1:0]           r_cur,   n_cur;
    logic                    r_pres,  n_pres;
    logic                    r_live [THREAD_SLOTS];
    logic                    n_live [THREAD_SLOTS];
    logic [TW-1:0]           r_rh,    n_rh;
    logic [TW-1:0]           r_rt,    n_rt;
    logic                    r_rne,   n_rne;
    logic signed [SEM_W-1:0] r_sv  [SEMAPHORES];
    logic signed [SEM_W-1:0] n_sv  [SEMAPHORES];
    logic [TW-1:0]           r_wh  [SEMAPHORES];
    logic [TW-1:0]           n_wh  [SEMAPHORES];
    logic [TW-1:0]           r_wt  [SEMAPHORES];
    logic [TW-1:0]           n_wt  [SEMAPHORES];
    logic                    r_wne [SEMAPHORES];
    logic                    n_wne [SEMAPHORES];

    t_link_wr                lw;
    t_status                 status;
    logic                    do_disp;
    logic                    do_push;
    logic [TW-1:0]           push_id;
    logic signed [SEM_W-1:0] sem_v;
    logic [OW-1:0]           cur_ext;

    always_comb begin
        n_cur   = r_cur;
        n_pres  = r_pres;
        n_live  = r_live;
        n_rh    = r_rh;
        n_rt    = r_rt;
        n_rne   = r_rne;
        n_sv    = r_sv;
        n_wh    = r_wh;
        n_wt    = r_wt;
        n_wne   = r_wne;
        lw      = '0;
        status  = ST_OK;
        do_disp = 1'b0;
        do_push = 1'b0;
        push_id = r_cur;
        sem_v   = r_sv[i_sem];

        if (i_fire) begin
            case (t_kind'(i_kind))
                K_CREATE: begin
                    if (r_live[i_tid]) begin
                        status = ST_EXISTS;
                    end else begin
                        n_live[i_tid] = 1'b1;
                        do_push       = 1'b1;
                        push_id       = i_tid;
                    end
                end
                K_YIELD: begin
                    if (!r_pres) begin
                        status  = ST_NO_RUN;
                        do_disp = 1'b1;
                    end else if (r_rne) begin
                        do_disp = 1'b1;
                        do_push = 1'b1;
                        push_id = r_cur;
                    end
                end
                K_TERMINATE: begin
                    if (!r_pres) begin
                        status = ST_NO_RUN;
                    end else begin
                        n_live[r_cur] = 1'b0;
                    end
                    do_disp = 1'b1;
                end
                K_SEM_INIT: begin
                    n_sv[i_sem]  = SEM_W'(signed'({1'b0, i_count}));
                    n_wne[i_sem] = 1'b0;
                end
                K_SEM_WAIT: begin
                    if (!r_pres) begin
                        status = ST_NO_RUN;
                    end else begin
                        if (sem_v == SEM_MIN) begin
                            status = ST_LIMIT;
                        end else begin
                            sem_v = sem_v - 8'sd1;
                        end
                        n_sv[i_sem] = sem_v;
                        if (sem_v[SEM_W-1]) begin
                            // block on the semaphore
                            if (r_wne[i_sem]) begin
                                lw.en   = 1'b1;
                                lw.addr = TID_MAX_W'(r_wt[i_sem]);
                                lw.data = TID_MAX_W'(r_cur);
                            end else begin
                                n_wh[i_sem] = r_cur;
                            end
                            n_wt[i_sem]  = r_cur;
                            n_wne[i_sem] = 1'b1;
                            do_disp      = 1'b1;
                        end
                    end
                end
                K_SEM_SIG: begin
                    if (sem_v == SEM_MAX) begin
                        status = ST_LIMIT;
                    end else begin
                        sem_v = sem_v + 8'sd1;
                    end
                    n_sv[i_sem] = sem_v;
                    if (r_wne[i_sem]) begin
                        push_id = r_wh[i_sem];
                        do_push = 1'b1;
                        if (r_wh[i_sem] == r_wt[i_sem]) begin
                            n_wne[i_sem] = 1'b0;
                        end else begin
                            n_wh[i_sem] = i_wait_next;
                        end
                    end
                end
                K_SEM_DEST: begin
                    if (r_wne[i_sem]) begin
                        // splice whole wait list onto ready tail
                        if (r_rne) begin
                            lw.en   = 1'b1;
                            lw.addr = TID_MAX_W'(r_rt);
                            lw.data = TID_MAX_W'(r_wh[i_sem]);
                        end else begin
                            n_rh = r_wh[i_sem];
                        end
                        n_rt         = r_wt[i_sem];
                        n_rne        = 1'b1;
                        n_wne[i_sem] = 1'b0;
                    end
                    n_sv[i_sem] = '0;
                end
                default: begin
                end
            endcase

            if (do_disp) begin
                if (r_rne) begin
                    n_cur  = r_rh;
                    n_pres = 1'b1;
                    if (r_rh == r_rt) begin
                        n_rne = 1'b0;
                    end else if (lw.en && lw.addr[TW-1:0] == r_rh) begin
                        n_rh = lw.data[TW-1:0];
                    end else begin
                        n_rh = i_ready_next;
                    end
                end else begin
                    n_cur  = '0;
                    n_pres = 1'b0;
                end
            end

            if (do_push) begin
                if (n_rne) begin
                    lw.en   = 1'b1;
                    lw.addr = TID_MAX_W'(n_rt);
                    lw.data = TID_MAX_W'(push_id);
                end else begin
                    n_rh = push_id;
                end
                n_rt  = push_id;
                n_rne = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_pres <= 1'b1;
            r_rh   <= '0;
            r_rt   <= '0;
            r_rne  <= 1'b0;
            for (int i = 0; i < THREAD_SLOTS; i++) begin
                r_live[i] <= (i == 0);
            end
            for (int j = 0; j < SEMAPHORES; j++) begin
                r_sv[j]  <= '0;
                r_wne[j] <= 1'b0;
            end
        end else begin
            r_cur  <= n_cur;
            r_pres <= n_pres;
            r_rh   <= n_rh;
            r_rt   <= n_rt;
            r_rne  <= n_rne;
            r_live <= n_live;
            r_sv   <= n_sv;
            r_wne  <= n_wne;
        end
    end

    // wait list pointers are only read behind their non-empty flag
    always_ff @(posedge i_clk) begin
        r_wh <= n_wh;
        r_wt <= n_wt;
    end

    assign cur_ext      = OW'(n_cur);
    assign o_link_wr    = lw;
    assign o_ready_addr = n_rh;
    assign o_wait_addr  = n_wh[i_new_sem];
    assign o_thread     = n_pres ? cur_ext[TID_W-1:0] : '0;
    assign o_present    = n_pres;
    assign o_switched   = (r_pres != n_pres) || (n_pres && (r_cur != n_cur));
    assign o_status     = status;

endmodule

@@ hw/rtl/semaphore_thread_scheduler.sv @@
// ----------------------------------------------------------------------------
// semaphore_thread_scheduler: thread scheduler with counting semaphores
// Pipeline: the request register loads at the accepting edge and the result
//   register loads when that request is processed, which waits while a held
//   result is not taken; throughput one request per cycle while results are
//   taken, set by the single-pass event logic and the lookahead next-pointer reads.
// Reset: synchronous; thread 0 runs, ready and wait lists empty, counts zero.
// ----------------------------------------------------------------------------
module semaphore_thread_scheduler #(
    parameter int THREAD_SLOTS = 16,
    parameter int SEMAPHORES   = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sts_req_if.sink   i_req,
    sts_res_if.source o_res
);
    import sts_pkg::*;

    localparam int TW = $clog2(THREAD_SLOTS);
    localparam int SW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;

    // request register
    logic                r_in_valid, n_in_valid;
    logic [KIND_W-1:0]   r_kind;
    logic [TW-1:0]       r_tid;
    logic [SW-1:0]       r_sem;
    logic [COUNT_W-1:0]  r_count;

    // result register
    logic                r_out_valid, n_out_valid;
    logic [TID_W-1:0]    r_thread;
    logic                r_present;
    logic                r_switched;
    logic [STATUS_W-1:0] r_status;

    logic                in_take;   // request enters the request register
    logic                fire;      // request register is processed
    logic [7:0]          tid_mod;
    logic [7:0]          sem_mod;
    logic [TW-1:0]       new_tid;
    logic [SW-1:0]       new_sem;

    t_link_wr            link_wr;
    logic [TW-1:0]       ready_addr;
    logic [TW-1:0]       wait_addr;
    logic [TW-1:0]       ready_next;
    logic [TW-1:0]       wait_next;
    logic [TID_W-1:0]    res_thread;
    logic                res_present;
    logic                res_switched;
    logic [STATUS_W-1:0] res_status;

    // Out-of-range ids wrap to the configured slot and semaphore counts.
    assign tid_mod = mod_small(8'(i_req.thread_slot), THREAD_SLOTS);
    assign sem_mod = mod_small(8'(i_req.sem_id), SEMAPHORES);
    assign new_tid = tid_mod[TW-1:0];
    assign new_sem = sem_mod[SW-1:0];

    // A request is processed whenever the result slot is free or draining,
    // and the request register refills in the same cycle.
    assign fire        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || fire;
    assign in_take     = i_req.valid && i_req.ready;

    assign n_in_valid  = in_take || (r_in_valid && !fire);
    assign n_out_valid = fire || (r_out_valid && !o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind  <= i_req.kind;
            r_tid   <= new_tid;
            r_sem   <= new_sem;
            r_count <= i_req.init_count;
        end
        if (fire) begin
            r_thread   <= res_thread;
            r_present  <= res_present;
            r_switched <= res_switched;
            r_status   <= res_status;
        end
    end

    // Scheduler state and the event logic of one request.
    sts_sched_core #(
        .THREAD_SLOTS (THREAD_SLOTS),
        .SEMAPHORES   (SEMAPHORES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_kind       (r_kind),
        .i_tid        (r_tid),
        .i_sem        (r_sem),
        .i_count      (r_count),
        .i_new_sem    (new_sem),
        .i_ready_next (ready_next),
        .i_wait_next  (wait_next),
        .o_link_wr    (link_wr),
        .o_ready_addr (ready_addr),
        .o_wait_addr  (wait_addr),
        .o_thread     (res_thread),
        .o_present    (res_present),
        .o_switched   (res_switched),
        .o_status     (res_status)
    );

    // Next pointers: the successor of the ready head is fetched every cycle
    // from the head the state is moving to; the successor of the addressed
    // wait head is fetched as a request enters. State changes only when a
    // request is processed, so both lookaheads are current when used.
    sts_link_mem #(
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_link (
        .i_clk        (i_clk),
        .i_wr         (link_wr),
        .i_ready_addr (ready_addr),
        .i_wait_addr  (wait_addr),
        .i_wait_load  (in_take),
        .o_ready_next (ready_next),
        .o_wait_next  (wait_next)
    );

    assign o_res.valid           = r_out_valid;
    assign o_res.running_thread  = r_thread;
    assign o_res.running_present = r_present;
    assign o_res.switched        = r_switched;
    assign o_res.status          = r_status;

endmodule

@@ bench/semaphore_thread_scheduler_check.sv @@
// ----------------------------------------------------------------------------
// semaphore_thread_scheduler_check: result checker for the thread scheduler
// Mirrors the scheduler state from accepted requests and compares every
// accepted result, field by field, with the oldest outstanding outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module semaphore_thread_scheduler_check (
    input  logic i_clk,
    input  logic i_rst_n,
    sts_req_if   i_req,
    sts_res_if   i_res,
    output int   o_pending,
    output int   o_errors,
    output int   o_checked,
    output int   o_idle
);
    import sts_pkg::*;

    localparam int THREAD_SLOTS = 16;
    localparam int SEMAPHORES   = 8;

    typedef struct packed {
        logic [TID_W-1:0] thread;
        logic             present;
        logic             switched;
        t_status          status;
    } t_outcome;

    t_outcome due_outcomes[$];

    // mirrored scheduler state
    logic [TID_W-1:0]        run_thread;
    logic                    run_present;
    logic [TID_W-1:0]        next_link [THREAD_SLOTS];
    logic                    thread_live [THREAD_SLOTS];
    logic [TID_W-1:0]        ready_head;
    logic [TID_W-1:0]        ready_tail;
    logic                    ready_any;
    logic signed [SEM_W-1:0] sem_level [SEMAPHORES];
    logic [TID_W-1:0]        wait_head [SEMAPHORES];
    logic [TID_W-1:0]        wait_tail [SEMAPHORES];
    logic                    wait_any [SEMAPHORES];

    int errors;
    int checked;
    int idle_seen;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("[%0t] result %0d: %s is %0d, expected %0d", $time, checked, what, got, want);
    endtask

    function automatic void make_ready(input logic [TID_W-1:0] t);
        if (ready_any) begin
            next_link[ready_tail] = t;
        end else begin
            ready_head = t;
        end
        ready_tail = t;
        ready_any  = 1'b1;
    endfunction

    // ready head takes the processor, or nothing runs
    function automatic void run_next();
        if (ready_any) begin
            run_thread  = ready_head;
            run_present = 1'b1;
            if (ready_head == ready_tail) begin
                ready_any = 1'b0;
            end else begin
                ready_head = next_link[ready_head];
            end
        end else begin
            run_thread  = '0;
            run_present = 1'b0;
        end
    endfunction

    function automatic t_outcome advance_schedule(input logic [KIND_W-1:0]  kind,
                                                  input logic [TID_W-1:0]   tid_in,
                                                  input logic [SID_W-1:0]   sid_in,
                                                  input logic [COUNT_W-1:0] init_in);
        logic [TID_W-1:0] tid;
        logic [SID_W-1:0] sid;
        logic [TID_W-1:0] prev_thread;
        logic             prev_present;
        logic [TID_W-1:0] t;
        t_status          status;
        t_outcome         o;
        tid          = TID_W'(tid_in % THREAD_SLOTS);
        sid          = SID_W'(sid_in % SEMAPHORES);
        prev_thread  = run_thread;
        prev_present = run_present;
        status       = ST_OK;
        case (kind)
            K_CREATE: begin
                if (thread_live[tid]) begin
                    status = ST_EXISTS;
                end else begin
                    thread_live[tid] = 1'b1;
                    make_ready(tid);
                end
            end
            K_YIELD: begin
                if (!run_present) begin
                    status = ST_NO_RUN;
                    run_next();
                end else if (ready_any) begin
                    t = run_thread;
                    run_next();
                    make_ready(t);
                end
            end
            K_TERMINATE: begin
                if (!run_present) begin
                    status = ST_NO_RUN;
                end else begin
                    thread_live[run_thread] = 1'b0;
                end
                run_next();
            end
            K_SEM_INIT: begin
                sem_level[sid] = {1'b0, init_in};
                wait_any[sid]  = 1'b0;
            end
            K_SEM_WAIT: begin
                if (!run_present) begin
                    status = ST_NO_RUN;
                end else begin
                    if (sem_level[sid] == SEM_MIN) begin
                        status = ST_LIMIT;
                    end else begin
                        sem_level[sid] = sem_level[sid] - 8'sd1;
                    end
                    if (sem_level[sid] < 0) begin
                        // running thread joins the wait list tail
                        if (wait_any[sid]) begin
                            next_link[wait_tail[sid]] = run_thread;
                        end else begin
                            wait_head[sid] = run_thread;
                        end
                        wait_tail[sid] = run_thread;
                        wait_any[sid]  = 1'b1;
                        run_next();
                    end
                end
            end
            K_SEM_SIG: begin
                if (sem_level[sid] == SEM_MAX) begin
                    status = ST_LIMIT;
                end else begin
                    sem_level[sid] = sem_level[sid] + 8'sd1;
                end
                if (wait_any[sid]) begin
                    t = wait_head[sid];
                    if (wait_head[sid] == wait_tail[sid]) begin
                        wait_any[sid] = 1'b0;
                    end else begin
                        wait_head[sid] = next_link[t];
                    end
                    make_ready(t);
                end
            end
            K_SEM_DEST: begin
                // whole wait list goes onto the ready tail in one step
                if (wait_any[sid]) begin
                    if (ready_any) begin
                        next_link[ready_tail] = wait_head[sid];
                    end else begin
                        ready_head = wait_head[sid];
                    end
                    ready_tail    = wait_tail[sid];
                    ready_any     = 1'b1;
                    wait_any[sid] = 1'b0;
                end
                sem_level[sid] = '0;
            end
            default: begin
            end
        endcase
        o.thread   = run_present ? run_thread : '0;
        o.present  = run_present;
        o.switched = (prev_present != run_present) ||
                     (run_present && prev_thread != run_thread);
        o.status   = status;
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            run_thread  = '0;
            run_present = 1'b1;
            ready_head  = '0;
            ready_tail  = '0;
            ready_any   = 1'b0;
            for (int i = 0; i < THREAD_SLOTS; i++) begin
                next_link[i]   = '0;
                thread_live[i] = (i == 0);
            end
            for (int i = 0; i < SEMAPHORES; i++) begin
                sem_level[i] = '0;
                wait_head[i] = '0;
                wait_tail[i] = '0;
                wait_any[i]  = 1'b0;
            end
            due_outcomes.delete();
        end else begin
            // result first: it can never belong to a request taken at this edge
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                if (due_outcomes.size() == 0) begin
                    report_mismatch("unrequested result, thread", i_res.running_thread, -1);
                end else begin
                    want = due_outcomes.pop_front();
                    if (i_res.running_thread !== want.thread)
                        report_mismatch("running_thread", i_res.running_thread, want.thread);
                    if (i_res.running_present !== want.present)
                        report_mismatch("running_present", i_res.running_present, want.present);
                    if (i_res.switched !== want.switched)
                        report_mismatch("switched", i_res.switched, want.switched);
                    if (i_res.status !== want.status)
                        report_mismatch("status", i_res.status, want.status);
                    checked++;
                    if (!want.present) begin
                        idle_seen++;
                    end
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                due_outcomes.push_back(advance_schedule(i_req.kind, i_req.thread_slot,
                                                        i_req.sem_id, i_req.init_count));
            end
        end
        o_pending <= due_outcomes.size();
        o_errors  <= errors;
        o_checked <= checked;
        o_idle    <= idle_seen;
    end

endmodule

@@ bench/semaphore_thread_scheduler_test.sv @@
// ----------------------------------------------------------------------------
// semaphore_thread_scheduler_test: top of the thread scheduler bench
// Drives a directed opening and about two thousand weighted random requests,
// with idle bursts on both channels, a long result back-pressure and a full
// drain; the checker beside the block does prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module semaphore_thread_scheduler_test;
    import sts_pkg::*;

    localparam int RESET_CYCLES  = 10;
    localparam int EVENTS        = 2000;  // requests in the whole run
    localparam int HOLD_AT       = 400;   // long result hold-off starts here
    localparam int HOLD_CYCLES   = 120;
    localparam int DRAIN_AT      = 1000;  // sender pauses here until all results are in
    localparam int CALM_FROM     = 1700;  // no idling on either side from here on
    localparam int STALL_LIMIT   = 2000;  // cycles with nothing moving before giving up
    localparam int SETTLE_CYCLES = 8;     // settle time after the final drain

    // kind 7 has no meaning; the block must leave everything alone
    localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;

    logic i_clk;
    logic i_rst_n;

    sts_req_if req_ch ();
    sts_res_if res_ch ();

    int pending;
    int errors;
    int checked;
    int idle_seen;

    int sent;               // requests accepted so far
    int kind_tally [8];
    bit sender_gaps;
    bit receiver_gaps;
    bit hold_done;
    int quiet;

    semaphore_thread_scheduler DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    semaphore_thread_scheduler_check CHECK (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_res     (res_ch),
        .o_pending (pending),
        .o_errors  (errors),
        .o_checked (checked),
        .o_idle    (idle_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // One request: optional idle burst first, then hold it until the block takes it.
    // Everything changes at the falling edge; acceptance is judged at the rising one.
    task automatic send_event(input logic [KIND_W-1:0]  k,
                              input logic [TID_W-1:0]   t,
                              input logic [SID_W-1:0]   s,
                              input logic [COUNT_W-1:0] c);
        int gap;
        gap = 0;
        if (sender_gaps && $urandom_range(0, 99) < 15) begin
            gap = $urandom_range(1, 17);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= k;
        req_ch.thread_slot <= t;
        req_ch.sem_id      <= s;
        req_ch.init_count  <= c;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        kind_tally[k]++;
        sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic await_drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        wait (pending == 0);
    endtask

    // counts mostly tiny so waits block; the top values push signals to the limit
    function automatic logic [COUNT_W-1:0] choose_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return COUNT_W'($urandom_range(0, 2));
        if (r < 75) return COUNT_W'($urandom);
        return (r < 88) ? 7'd127 : 7'd126;
    endfunction

    // Weighted mix. Re-initialising a semaphore normally follows a destroy, so
    // that its waiters go back to the ready list; a bare init over waiters strands
    // those threads for good, so it stays rare to keep the thread pool alive.
    task automatic random_event();
        int               pick;
        logic [SID_W-1:0] s;
        pick = $urandom_range(0, 99);
        // most semaphore traffic on three ids so that wait lists grow long
        s = ($urandom_range(0, 3) != 0) ? SID_W'($urandom_range(0, 2))
                                        : SID_W'($urandom_range(0, 7));
        if (pick < 22) begin
            send_event(K_CREATE, TID_W'($urandom), s, COUNT_W'($urandom));
        end else if (pick < 35) begin
            send_event(K_YIELD, TID_W'($urandom), s, COUNT_W'($urandom));
        end else if (pick < 43) begin
            send_event(K_TERMINATE, TID_W'($urandom), s, COUNT_W'($urandom));
        end else if (pick < 63) begin
            send_event(K_SEM_WAIT, TID_W'($urandom), s, COUNT_W'($urandom));
        end else if (pick < 78) begin
            send_event(K_SEM_SIG, TID_W'($urandom), s, COUNT_W'($urandom));
        end else if (pick < 84) begin
            send_event(K_SEM_DEST, TID_W'($urandom), s, COUNT_W'($urandom));
            send_event(K_SEM_INIT, TID_W'($urandom), s, choose_count());
        end else if (pick < 87) begin
            if ($urandom_range(0, 3) == 0) begin
                send_event(K_SEM_INIT, TID_W'($urandom), s, choose_count());
            end else begin
                send_event(K_SEM_DEST, TID_W'($urandom), s, COUNT_W'($urandom));
            end
        end else if (pick < 89) begin
            send_event(K_UNUSED, TID_W'($urandom), s, COUNT_W'($urandom));
        end else begin
            send_event(K_SEM_SIG, TID_W'($urandom), s, COUNT_W'($urandom));
        end
    endtask

    // Result side: random ready bursts, plus one long hold-off so that the
    // block fills up and pushes back on its request channel.
    initial begin : receiver
        int gap;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!hold_done && sent >= HOLD_AT) begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (receiver_gaps && $urandom_range(0, 99) < 10) begin
                gap = $urandom_range(1, 17);
                res_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a stretch with no request and no result moving ends the run.
    initial begin : watchdog
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[%0t] stall: nothing moved for %0d cycles, %0d results outstanding",
                 $time, quiet, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int segment;
        bit drained_mid;
        req_ch.valid       = 1'b0;
        req_ch.kind        = '0;
        req_ch.thread_slot = '0;
        req_ch.sem_id      = '0;
        req_ch.init_count  = '0;
        i_rst_n            = 1'b0;
        sender_gaps        = 1'b1;
        receiver_gaps      = 1'b1;
        segment            = -1;
        drained_mid        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed opening: thread 0 runs, nothing else exists yet ---
        send_event(K_YIELD,     4'd0,  3'd0, 7'd0);    // empty ready list: no switch
        send_event(K_CREATE,    4'd0,  3'd0, 7'd0);    // main thread already live
        send_event(K_CREATE,    4'd15, 3'd0, 7'd0);
        send_event(K_CREATE,    4'd5,  3'd0, 7'd0);
        send_event(K_YIELD,     4'd0,  3'd0, 7'd0);    // 15 runs, 0 to the tail
        send_event(K_SEM_INIT,  4'd0,  3'd7, 7'd127);
        send_event(K_SEM_SIG,   4'd0,  3'd7, 7'd0);    // count already at top
        send_event(K_SEM_INIT,  4'd0,  3'd0, 7'd0);
        send_event(K_SEM_WAIT,  4'd0,  3'd0, 7'd0);    // 15 blocks, 5 runs
        send_event(K_SEM_WAIT,  4'd0,  3'd0, 7'd0);    // 5 blocks, 0 runs
        send_event(K_SEM_SIG,   4'd0,  3'd0, 7'd0);    // wakes 15
        send_event(K_SEM_DEST,  4'd0,  3'd0, 7'd0);    // 5 spliced onto ready
        send_event(K_SEM_INIT,  4'd0,  3'd1, 7'd0);
        send_event(K_SEM_WAIT,  4'd0,  3'd1, 7'd0);    // 0 blocks
        send_event(K_SEM_INIT,  4'd0,  3'd1, 7'd0);    // init drops thread 0 from the list
        send_event(K_CREATE,    4'd0,  3'd0, 7'd0);    // stranded thread still live
        send_event(K_TERMINATE, 4'd0,  3'd0, 7'd0);
        send_event(K_TERMINATE, 4'd0,  3'd0, 7'd0);    // nothing left: idle
        send_event(K_YIELD,     4'd0,  3'd0, 7'd0);    // idle yield, stays idle
        send_event(K_SEM_WAIT,  4'd0,  3'd2, 7'd0);    // idle wait
        send_event(K_TERMINATE, 4'd0,  3'd0, 7'd0);    // idle terminate
        send_event(K_CREATE,    4'd9,  3'd0, 7'd0);
        send_event(K_YIELD,     4'd0,  3'd0, 7'd0);    // idle yield dispatches 9
        send_event(K_UNUSED,    4'd15, 3'd7, 7'd127);
        send_event(K_CREATE,    4'd15, 3'd0, 7'd0);
        await_drain();

        // --- random part, idling switched per segment of a hundred requests ---
        while (sent < EVENTS) begin
            if (sent >= CALM_FROM) begin
                sender_gaps   = 1'b0;
                receiver_gaps = 1'b0;
            end else if (sent / 100 != segment) begin
                segment       = sent / 100;
                sender_gaps   = ($urandom_range(0, 2) != 0);
                receiver_gaps = ($urandom_range(0, 2) != 0);
            end
            if (!drained_mid && sent >= DRAIN_AT) begin
                drained_mid = 1'b1;
                await_drain();
            end
            random_event();
        end

        await_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display(
            "%0d requests: cre %0d yld %0d trm %0d ini %0d wai %0d sig %0d des %0d unk %0d",
            sent, kind_tally[K_CREATE], kind_tally[K_YIELD], kind_tally[K_TERMINATE],
            kind_tally[K_SEM_INIT], kind_tally[K_SEM_WAIT], kind_tally[K_SEM_SIG],
            kind_tally[K_SEM_DEST], kind_tally[K_UNUSED]);
        $display("%0d results compared, %0d of them with no thread running",
                 checked, idle_seen);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
